FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the relay output controller.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define ROC_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ROC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ROC_ASSERT_NOW(label, clk, rst_n, a, b)
`define ROC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/roc_pkg.sv
// Types and constants of the relay output controller.
// No dependencies; roc_cfg, roc_core and relay_output_controller use it by scoped names.
`default_nettype none
package roc_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CHAN_W     = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF_SECONDS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_ENABLE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_ON_SECONDS = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_SECONDS   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_NUMBER    = 8'd5;

  typedef struct packed {
    logic              auto_off_enable;
    logic [TIME_W-1:0] auto_off_seconds;
    logic              motion_enable;
    logic [TIME_W-1:0] motion_on_seconds;
    logic [TIME_W-1:0] holdoff_seconds;
    logic [CHAN_W-1:0] channel_number;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_sec;
    logic              toggle_level;
    logic              reset_level;
    logic              panic_level;
    logic              motion_level;
    logic              bus_set_valid;
    logic              bus_set_value;
    logic              hw_output_level;
  } in_item_t;

  typedef struct packed {
    logic              relay_on;
    logic              bus_written;
    logic              hw_written;
    logic [CHAN_W-1:0] channel;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_word_t;

endpackage
`default_nettype wire

FILE: hw/rtl/roc_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Used for the input, result and configuration channels; types from roc_pkg.
`default_nettype none
interface roc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/relay_output_controller.sv
// Relay output controller: one poll word in, one result word out.
// Inputs arrive on in_s, results leave on out_m, registers are written
// through cfg_w (index 0..5; other indexes are ignored). cfg_w is always
// ready.
// Each poll word is captured in an input register; the step logic then runs
// it against the relay state and the result is written into the output
// register. One word is accepted in every cycle while the receiver does not
// stall: the two registers form a pipeline that advances whenever the output
// register is empty or is being taken, and the relay state is updated in the
// same cycle as the result.
// When the receiver stalls, the output register holds its word, the input
// register then fills and in_s.ready drops until out_m is taken again.
// Reset (rst_n low, synchronous) empties both registers without clearing
// their data, clears the configuration and relay state to zero and marks the
// next poll as the first one, whose physical output level loads the relay.
// Depends on roc_pkg, roc_stream_if, roc_cfg, roc_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module relay_output_controller (
  input  wire logic     clk,
  input  wire logic     rst_n,
  roc_stream_if.sink    in_s,
  roc_stream_if.source  out_m,
  roc_stream_if.sink    cfg_w
);

  roc_pkg::cfg_t      cfg;
  roc_pkg::in_item_t  s1_data_r;
  logic               s1_valid_r;
  roc_pkg::out_item_t step_result;
  roc_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               advance;
  logic               in_take;

  assign cfg_w.ready = 1'b1;

  roc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_w.valid),
    .wr_index (cfg_w.data.index),
    .wr_data  (cfg_w.data.data),
    .cfg      (cfg)
  );

  // The held word moves on when the output register is free or being taken.
  assign advance    = s1_valid_r && (!out_valid_r || out_m.ready);
  assign in_s.ready = !s1_valid_r || advance;
  assign in_take    = in_s.valid && in_s.ready;

  roc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .cfg    (cfg),
    .item   (s1_data_r),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_s.data;
    end
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_m.valid = out_valid_r;
  assign out_m.data  = out_data_r;

  `ROC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_s.ready,
                  s1_valid_r && out_valid_r && !out_m.ready)
  `ROC_ASSERT_NEXT(a_step_fills_output, clk, rst_n, advance, out_valid_r)
  `ROC_ASSERT_NEXT(a_held_word_kept, clk, rst_n, s1_valid_r && !advance, s1_valid_r)

endmodule
`default_nettype wire

FILE: hw/rtl/roc_cfg.sv
// Configuration register file of the relay output controller.
// Depends on roc_pkg for the register indexes and cfg_t.
`default_nettype none
module roc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [roc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [roc_pkg::CFG_DATA_W-1:0] wr_data,
  output roc_pkg::cfg_t                       cfg
);

  roc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        roc_pkg::REG_AUTO_OFF_ENABLE:   cfg_r.auto_off_enable   <= wr_data[0];
        roc_pkg::REG_AUTO_OFF_SECONDS:  cfg_r.auto_off_seconds  <= wr_data;
        roc_pkg::REG_MOTION_ENABLE:     cfg_r.motion_enable     <= wr_data[0];
        roc_pkg::REG_MOTION_ON_SECONDS: cfg_r.motion_on_seconds <= wr_data;
        roc_pkg::REG_HOLDOFF_SECONDS:   cfg_r.holdoff_seconds   <= wr_data;
        roc_pkg::REG_CHANNEL_NUMBER:
          cfg_r.channel_number <= wr_data[roc_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hw/rtl/roc_core.sv
// Relay state and the per-poll step logic of the relay output controller.
// Depends on roc_pkg; state advances only on a cycle with step high.
`default_nettype none
module roc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire roc_pkg::cfg_t      cfg,
  input  wire roc_pkg::in_item_t  item,
  output wire roc_pkg::out_item_t result
);

  localparam int unsigned TW = roc_pkg::TIME_W;

  logic          relay_r, relay_nxt;
  logic          mirror_r, mirror_nxt;
  logic          first_r, first_nxt;
  logic          tgl_prev_r, rst_prev_r, pan_prev_r, mot_prev_r;
  logic          armed_r, armed_nxt;
  logic          armed_prev_r;
  logic          panic_r, panic_nxt;
  logic          saved_r, saved_nxt;
  logic          hold_r, hold_nxt;
  logic [TW-1:0] hold_start_r, hold_start_nxt;
  logic          run_r, run_nxt;
  logic [TW-1:0] run_start_r, run_start_nxt;
  logic [TW-1:0] ao_start_r, ao_start_nxt;

  logic [TW-1:0] hold_diff, run_diff, ao_diff;
  logic          hold_done, run_done_old, ao_done_old;
  logic          bus_wr, hw_wr;

  // Elapsed tests against the stored start times; wrap modulo 2^32.
  assign hold_diff    = item.now_sec - hold_start_r;
  assign run_diff     = item.now_sec - run_start_r;
  assign ao_diff      = item.now_sec - ao_start_r;
  assign hold_done    = hold_diff >= cfg.holdoff_seconds;
  assign run_done_old = run_diff >= cfg.motion_on_seconds;
  assign ao_done_old  = ao_diff >= cfg.auto_off_seconds;

  always_comb begin
    logic run_started;
    logic ao_restart;
    logic run_done;
    logic ao_done;

    relay_nxt      = relay_r;
    mirror_nxt     = item.bus_set_valid ? item.bus_set_value : mirror_r;
    first_nxt      = first_r;
    armed_nxt      = armed_r;
    panic_nxt      = panic_r;
    saved_nxt      = saved_r;
    hold_nxt       = hold_r;
    hold_start_nxt = hold_start_r;
    run_nxt        = run_r;
    run_start_nxt  = run_start_r;
    ao_start_nxt   = ao_start_r;
    bus_wr         = 1'b0;
    hw_wr          = 1'b0;
    run_started    = 1'b0;
    ao_restart     = 1'b0;
    run_done       = 1'b0;

    // Motion: hold-off after re-arming, then a timed run per rising edge.
    if (cfg.motion_enable && armed_r) begin
      if (!armed_prev_r) begin
        hold_start_nxt = item.now_sec;
        hold_nxt       = 1'b1;
      end else if (hold_r) begin
        if (hold_done) begin
          hold_nxt = 1'b0;
        end
      end else begin
        if (item.motion_level && !mot_prev_r && !relay_nxt) begin
          run_nxt       = 1'b1;
          relay_nxt     = 1'b1;
          mirror_nxt    = 1'b1;
          bus_wr        = 1'b1;
          run_start_nxt = item.now_sec;
          run_started   = 1'b1;
        end
        // A run that starts now has elapsed only if its length is zero.
        run_done = run_started ? (cfg.motion_on_seconds == '0) : run_done_old;
        if (run_nxt && run_done) begin
          relay_nxt  = 1'b0;
          mirror_nxt = 1'b0;
          bus_wr     = 1'b1;
          run_nxt    = 1'b0;
        end
      end
    end

    // Panic: the first edge forces the relay on, the next restores it.
    if (item.panic_level && !pan_prev_r) begin
      if (!panic_r) begin
        saved_nxt = relay_nxt;
        relay_nxt = 1'b1;
        armed_nxt = 1'b0;
        panic_nxt = 1'b1;
      end else begin
        relay_nxt = saved_r;
        armed_nxt = 1'b1;
        panic_nxt = 1'b0;
      end
      mirror_nxt = relay_nxt;
      bus_wr     = 1'b1;
    end

    if (item.reset_level && !rst_prev_r) begin
      relay_nxt  = 1'b0;
      mirror_nxt = 1'b0;
      bus_wr     = 1'b1;
      armed_nxt  = 1'b1;
    end

    if (first_r) begin
      relay_nxt  = item.hw_output_level;
      mirror_nxt = item.hw_output_level;
      bus_wr     = 1'b1;
      first_nxt  = 1'b0;
    end

    if (item.toggle_level && !tgl_prev_r) begin
      relay_nxt    = !relay_nxt;
      mirror_nxt   = relay_nxt;
      bus_wr       = 1'b1;
      armed_nxt    = !relay_nxt;
      ao_start_nxt = item.now_sec;
      ao_restart   = 1'b1;
    end

    // Bus sync: a differing mirror value drives the relay and the output.
    if (mirror_nxt != relay_nxt) begin
      relay_nxt    = mirror_nxt;
      hw_wr        = 1'b1;
      armed_nxt    = !relay_nxt;
      ao_start_nxt = item.now_sec;
      ao_restart   = 1'b1;
    end

    ao_done = ao_restart ? (cfg.auto_off_seconds == '0) : ao_done_old;
    if (relay_nxt && cfg.auto_off_enable && ao_done) begin
      relay_nxt  = 1'b0;
      mirror_nxt = 1'b0;
      bus_wr     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r      <= 1'b0;
      mirror_r     <= 1'b0;
      first_r      <= 1'b1;
      tgl_prev_r   <= 1'b0;
      rst_prev_r   <= 1'b0;
      pan_prev_r   <= 1'b0;
      mot_prev_r   <= 1'b0;
      armed_r      <= 1'b0;
      armed_prev_r <= 1'b0;
      panic_r      <= 1'b0;
      saved_r      <= 1'b0;
      hold_r       <= 1'b0;
      hold_start_r <= '0;
      run_r        <= 1'b0;
      run_start_r  <= '0;
      ao_start_r   <= '0;
    end else if (step) begin
      relay_r      <= relay_nxt;
      mirror_r     <= mirror_nxt;
      first_r      <= first_nxt;
      tgl_prev_r   <= item.toggle_level;
      rst_prev_r   <= item.reset_level;
      pan_prev_r   <= item.panic_level;
      mot_prev_r   <= item.motion_level;
      armed_r      <= armed_nxt;
      armed_prev_r <= armed_r;
      panic_r      <= panic_nxt;
      saved_r      <= saved_nxt;
      hold_r       <= hold_nxt;
      hold_start_r <= hold_start_nxt;
      run_r        <= run_nxt;
      run_start_r  <= run_start_nxt;
      ao_start_r   <= ao_start_nxt;
    end
  end

  assign result.relay_on    = relay_nxt;
  assign result.bus_written = bus_wr;
  assign result.hw_written  = hw_wr;
  assign result.channel     = cfg.channel_number;

endmodule
`default_nettype wire
